FILE: sv/rpr_pkg.sv
// Shared types and constants for the relay/PID regulator.
// No dependencies; relay_pid_regulator_unit uses it by scoped names.
package rpr_pkg;

  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_GAIN_FRAC_BITS = 8;

  localparam int GAIN_BITS     = 16;
  localparam int GATE_BITS     = 16;
  localparam int INTEG_BITS    = 32;
  localparam int ACTION_BITS   = 7;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  localparam logic [ACTION_BITS-1:0] ACTION_MAX = 7'd100;

  localparam logic signed [INTEG_BITS-1:0] INTEG_MIN_RESET = -32'sd10000;
  localparam logic signed [INTEG_BITS-1:0] INTEG_MAX_RESET = 32'sd10000;

  typedef enum logic [1:0] {
    MODE_MANUAL = 2'd0,
    MODE_RELAY  = 2'd1,
    MODE_PID    = 2'd2,
    MODE_OFF    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODE       = 3'd0,
    CFG_TARGET     = 3'd1,
    CFG_RELAY_GATE = 3'd2,
    CFG_GAIN_P     = 3'd3,
    CFG_GAIN_I     = 3'd4,
    CFG_GAIN_D     = 3'd5,
    CFG_INTEG_MIN  = 3'd6,
    CFG_INTEG_MAX  = 3'd7
  } cfg_idx_e;

endpackage

FILE: sv/relay_pid_regulator_unit.sv
// Relay / PID regulator: four-stage pipeline from input word to result word.
// A word accepted into stage 0 moves through stages 1, 2 and 3 before it shows on out_valid_o.
// Throughput: one word per cycle while the output is not stalled; the error, integral and
// previous-error update is a single add and clamp in stage one, so it keeps up with back-to-back words.
// Stages hold words while the output is stalled, so input is taken until all fill.
// Reset (rst_ni low, asynchronous) restores register defaults and clears the regulator state and valids.
module relay_pid_regulator_unit #(
  parameter int SAMPLE_BITS    = rpr_pkg::DEF_SAMPLE_BITS,
  parameter int GAIN_FRAC_BITS = rpr_pkg::DEF_GAIN_FRAC_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write channel.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rpr_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [rpr_pkg::CFG_DATA_BITS-1:0]    cfg_data_i,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 kind_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_i,
  input  logic [rpr_pkg::ACTION_BITS-1:0]      new_action_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [rpr_pkg::ACTION_BITS-1:0]      action_o,
  output logic signed [SAMPLE_BITS:0]          error_o
);

  localparam int EW   = SAMPLE_BITS + 1;
  localparam int GW   = rpr_pkg::GAIN_BITS;
  localparam int IW   = rpr_pkg::INTEG_BITS;
  localparam int AW   = rpr_pkg::ACTION_BITS;
  localparam int CW   = ((EW > rpr_pkg::GATE_BITS) ? EW : rpr_pkg::GATE_BITS) + 2;
  localparam int PEW  = EW + GW;
  localparam int PIW  = IW + GW;
  localparam int PDW  = EW + 1 + GW;
  localparam int SUMW = ((PIW > PDW) ? PIW : PDW) + 2;

  // Configuration registers.
  rpr_pkg::mode_e                   mode_q;
  logic signed [SAMPLE_BITS-1:0]    target_q;
  logic [rpr_pkg::GATE_BITS-1:0]    gate_q;
  logic signed [GW-1:0]             gain_p_q, gain_i_q, gain_d_q;
  logic signed [IW-1:0]             integ_min_q, integ_max_q;

  // Regulator state.
  logic [AW-1:0]                    held_q;
  logic signed [IW-1:0]             integ_q;
  logic signed [EW-1:0]             prev_err_q;
  logic signed [EW-1:0]             last_err_q;

  // Pipeline valids and loads.
  logic v0_q, v1_q, v2_q, v3_q;
  logic ld0, ld1, ld2, ld3;

  // Stage 0: input register.
  logic                             r0_kind_q;
  logic signed [SAMPLE_BITS-1:0]    r0_sample_q;
  logic [AW-1:0]                    r0_action_q;

  // Stage 1: error, integral, derivative difference and relay flags.
  logic                             r1_kind_q;
  logic [AW-1:0]                    r1_action_q;
  logic signed [EW-1:0]             r1_err_q;
  logic signed [IW-1:0]             r1_integ_q;
  logic signed [EW:0]               r1_diff_q;
  logic signed [EW-1:0]             r1_out_err_q;
  logic                             r1_lo_q, r1_hi_q;

  // Stage 2: products.
  logic                             r2_kind_q;
  logic [AW-1:0]                    r2_action_q;
  logic signed [PEW-1:0]            r2_pe_q;
  logic signed [PIW-1:0]            r2_pi_q;
  logic signed [PDW-1:0]            r2_pd_q;
  logic signed [EW-1:0]             r2_out_err_q;
  logic                             r2_lo_q, r2_hi_q;

  // Stage 3: result register.
  logic [AW-1:0]                    r3_action_q;
  logic signed [EW-1:0]             r3_err_q;

  // Combinational values.
  logic signed [EW-1:0]             err_d;
  logic signed [IW+1:0]             integ_sum;
  logic signed [IW-1:0]             integ_d;
  logic signed [CW-1:0]             err_x, gate_x;
  logic                             upd_err, upd_pid;
  logic signed [SUMW-1:0]           pid_sum, pid_shift;
  logic [AW-1:0]                    pid_action, held_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= rpr_pkg::MODE_OFF;
      target_q    <= '0;
      gate_q      <= '0;
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      integ_min_q <= rpr_pkg::INTEG_MIN_RESET;
      integ_max_q <= rpr_pkg::INTEG_MAX_RESET;
    end else if (cfg_valid_i) begin
      unique case (rpr_pkg::cfg_idx_e'(cfg_index_i))
        rpr_pkg::CFG_MODE:       mode_q      <= rpr_pkg::mode_e'(cfg_data_i[1:0]);
        rpr_pkg::CFG_TARGET:     target_q    <= cfg_data_i[SAMPLE_BITS-1:0];
        rpr_pkg::CFG_RELAY_GATE: gate_q      <= cfg_data_i[rpr_pkg::GATE_BITS-1:0];
        rpr_pkg::CFG_GAIN_P:     gain_p_q    <= cfg_data_i[GW-1:0];
        rpr_pkg::CFG_GAIN_I:     gain_i_q    <= cfg_data_i[GW-1:0];
        rpr_pkg::CFG_GAIN_D:     gain_d_q    <= cfg_data_i[GW-1:0];
        rpr_pkg::CFG_INTEG_MIN:  integ_min_q <= cfg_data_i[IW-1:0];
        rpr_pkg::CFG_INTEG_MAX:  integ_max_q <= cfg_data_i[IW-1:0];
      endcase
    end
  end

  // A stage loads when it is empty or its word moves on in the same cycle.
  assign ld3 = !v3_q || !out_stall_i;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;
  assign ld0 = !v0_q || ld1;
  assign in_stall_o = !ld0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ld0) v0_q <= in_valid_i;
      if (ld1) v1_q <= v0_q;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q;
    end
  end

  // Stage 1 logic.
  always_comb begin
    err_d     = EW'(target_q) - EW'(r0_sample_q);
    integ_sum = (IW+2)'(integ_q) + (IW+2)'(err_d);
    if (integ_sum > (IW+2)'(integ_max_q)) begin
      integ_d = integ_max_q;
    end else if (integ_sum < (IW+2)'(integ_min_q)) begin
      integ_d = integ_min_q;
    end else begin
      integ_d = integ_sum[IW-1:0];
    end
    err_x   = CW'(err_d);
    gate_x  = CW'(signed'({1'b0, gate_q}));
    upd_err = v0_q && ld1 && !r0_kind_q
              && (mode_q == rpr_pkg::MODE_RELAY || mode_q == rpr_pkg::MODE_PID);
    upd_pid = upd_err && (mode_q == rpr_pkg::MODE_PID);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q    <= '0;
      prev_err_q <= '0;
      last_err_q <= '0;
    end else begin
      if (upd_err) last_err_q <= err_d;
      if (upd_pid) begin
        integ_q    <= integ_d;
        prev_err_q <= err_d;
      end
    end
  end

  // Stage 3 logic: truncation toward zero and flooring agree once negatives clamp to 0.
  always_comb begin
    pid_sum   = SUMW'(r2_pe_q) + SUMW'(r2_pi_q) + SUMW'(r2_pd_q);
    pid_shift = pid_sum >>> GAIN_FRAC_BITS;
    if (pid_shift[SUMW-1]) begin
      pid_action = '0;
    end else if (pid_shift > signed'(SUMW'(rpr_pkg::ACTION_MAX))) begin
      pid_action = rpr_pkg::ACTION_MAX;
    end else begin
      pid_action = pid_shift[AW-1:0];
    end

    held_d = held_q;
    if (r2_kind_q) begin
      held_d = r2_action_q;
    end else if (mode_q == rpr_pkg::MODE_RELAY) begin
      if (r2_lo_q) begin
        held_d = '0;
      end else if (r2_hi_q) begin
        held_d = rpr_pkg::ACTION_MAX;
      end
    end else if (mode_q == rpr_pkg::MODE_PID) begin
      held_d = pid_action;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (v2_q && ld3) begin
      held_q <= held_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ld0) begin
      r0_kind_q   <= kind_i;
      r0_sample_q <= sample_i;
      r0_action_q <= new_action_i;
    end
    if (ld1) begin
      r1_kind_q    <= r0_kind_q;
      r1_action_q  <= (r0_action_q > rpr_pkg::ACTION_MAX) ? rpr_pkg::ACTION_MAX
                                                          : r0_action_q;
      r1_err_q     <= err_d;
      r1_integ_q   <= integ_d;
      r1_diff_q    <= (EW+1)'(err_d) - (EW+1)'(prev_err_q);
      r1_out_err_q <= upd_err ? err_d : last_err_q;
      r1_lo_q      <= (err_x + gate_x) < CW'(0);
      r1_hi_q      <= err_x > gate_x;
    end
    if (ld2) begin
      r2_kind_q    <= r1_kind_q;
      r2_action_q  <= r1_action_q;
      r2_pe_q      <= PEW'(r1_err_q) * PEW'(gain_p_q);
      r2_pi_q      <= PIW'(r1_integ_q) * PIW'(gain_i_q);
      r2_pd_q      <= PDW'(r1_diff_q) * PDW'(gain_d_q);
      r2_out_err_q <= r1_out_err_q;
      r2_lo_q      <= r1_lo_q;
      r2_hi_q      <= r1_hi_q;
    end
    if (ld3) begin
      r3_action_q <= (mode_q == rpr_pkg::MODE_OFF) ? '0 : held_d;
      r3_err_q    <= r2_out_err_q;
    end
  end

  assign out_valid_o = v3_q;
  assign action_o    = r3_action_q;
  assign error_o     = r3_err_q;

  // The input side stalls only when every stage holds a word.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v0_q && v1_q && v2_q && v3_q))
    else $error("input stalled while the pipeline has a bubble");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o <= rpr_pkg::ACTION_MAX))
    else $error("action above full scale");

  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld3 && v2_q && mode_q == rpr_pkg::MODE_OFF) |=> (action_o == '0))
    else $error("nonzero action in off mode");

  // With crossed bounds the integral can settle on a lower bound above the upper one.
  a_integ_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_pid |=> (integ_q <= $past(integ_max_q) || integ_q == $past(integ_min_q)))
    else $error("integral above its upper bound");

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for relay_pid_regulator_unit: directed and random words
// with random idling on both sides, checked against a cycle-free regulator model.
// Depends on rpr_pkg and relay_pid_regulator_unit only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W       = rpr_pkg::DEF_SAMPLE_BITS;
  localparam longint FRAC_DIV   = longint'(1) << rpr_pkg::DEF_GAIN_FRAC_BITS;
  localparam int PIPE_LATENCY   = 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 95;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [rpr_pkg::ACTION_BITS-1:0] action;
    logic signed [SAMPLE_W:0]        error;
  } action_word_t;

  // Tracks the regulator state and the result words still owed by the block.
  class regulator_tracker;
    rpr_pkg::mode_e                        run_mode = rpr_pkg::MODE_OFF;
    logic signed [SAMPLE_W-1:0]            set_point = '0;
    logic [rpr_pkg::GATE_BITS-1:0]         gate = '0;
    logic signed [rpr_pkg::GAIN_BITS-1:0]  kp = '0, ki = '0, kd = '0;
    logic signed [rpr_pkg::INTEG_BITS-1:0] integ_lo = rpr_pkg::INTEG_MIN_RESET;
    logic signed [rpr_pkg::INTEG_BITS-1:0] integ_hi = rpr_pkg::INTEG_MAX_RESET;

    logic [rpr_pkg::ACTION_BITS-1:0]       held_act = '0;
    logic signed [rpr_pkg::INTEG_BITS-1:0] integ_acc = '0;
    logic signed [SAMPLE_W:0]              prev_err = '0;
    logic signed [SAMPLE_W:0]              last_err = '0;

    action_word_t pending_results[$];
    int           mismatches = 0;

    function void write_reg(rpr_pkg::cfg_idx_e idx,
                            logic [rpr_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        rpr_pkg::CFG_MODE:       run_mode = rpr_pkg::mode_e'(data[1:0]);
        rpr_pkg::CFG_TARGET:     set_point = data[SAMPLE_W-1:0];
        rpr_pkg::CFG_RELAY_GATE: gate = data[rpr_pkg::GATE_BITS-1:0];
        rpr_pkg::CFG_GAIN_P:     kp = data[rpr_pkg::GAIN_BITS-1:0];
        rpr_pkg::CFG_GAIN_I:     ki = data[rpr_pkg::GAIN_BITS-1:0];
        rpr_pkg::CFG_GAIN_D:     kd = data[rpr_pkg::GAIN_BITS-1:0];
        rpr_pkg::CFG_INTEG_MIN:  integ_lo = data[rpr_pkg::INTEG_BITS-1:0];
        rpr_pkg::CFG_INTEG_MAX:  integ_hi = data[rpr_pkg::INTEG_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void take_input(logic kind, logic signed [SAMPLE_W-1:0] smp,
                             logic [rpr_pkg::ACTION_BITS-1:0] new_act);
      longint err;
      longint acc;
      action_word_t want;
      if (kind) begin
        held_act = (new_act > rpr_pkg::ACTION_MAX) ? rpr_pkg::ACTION_MAX : new_act;
      end else if (run_mode == rpr_pkg::MODE_RELAY) begin
        err = longint'(set_point) - longint'(smp);
        last_err = (SAMPLE_W+1)'(err);
        if (-err > longint'(gate)) held_act = '0;
        else if (err > longint'(gate)) held_act = rpr_pkg::ACTION_MAX;
      end else if (run_mode == rpr_pkg::MODE_PID) begin
        err = longint'(set_point) - longint'(smp);
        last_err = (SAMPLE_W+1)'(err);
        // Upper bound first: crossed bounds give the maximum above it, else the minimum.
        acc = longint'(integ_acc) + err;
        if (acc > longint'(integ_hi)) acc = integ_hi;
        else if (acc < longint'(integ_lo)) acc = integ_lo;
        integ_acc = (rpr_pkg::INTEG_BITS)'(acc);
        acc = err * longint'(kp) + longint'(integ_acc) * longint'(ki)
              + (err - longint'(prev_err)) * longint'(kd);
        prev_err = (SAMPLE_W+1)'(err);
        acc = acc / FRAC_DIV;
        if (acc > longint'(rpr_pkg::ACTION_MAX)) acc = rpr_pkg::ACTION_MAX;
        else if (acc < 0) acc = 0;
        held_act = (rpr_pkg::ACTION_BITS)'(acc);
      end
      want.action = (run_mode == rpr_pkg::MODE_OFF) ? '0 : held_act;
      want.error  = last_err;
      pending_results.push_back(want);
    endfunction

    function void check_result(logic [rpr_pkg::ACTION_BITS-1:0] act,
                               logic signed [SAMPLE_W:0] err);
      action_word_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result word: action %0d error %0d", act, err);
        return;
      end
      want = pending_results.pop_front();
      if (act !== want.action || err !== want.error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result mismatch: action exp %0d got %0d, error exp %0d got %0d",
                   want.action, act, want.error, err);
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                              cfg_valid = 1'b0;
  rpr_pkg::cfg_idx_e                 cfg_index = rpr_pkg::CFG_MODE;
  logic [rpr_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              kind      = 1'b0;
  logic signed [SAMPLE_W-1:0]        sample    = '0;
  logic [rpr_pkg::ACTION_BITS-1:0]   new_action = '0;
  logic                              out_stall = 1'b0;

  logic                              cfg_ready_o;
  logic                              in_stall_o;
  logic                              out_valid_o;
  logic [rpr_pkg::ACTION_BITS-1:0]   action_o;
  logic signed [SAMPLE_W:0]          error_o;

  logic hold_req = 1'b0;
  int   idle_cycles = 0;

  regulator_tracker chk = new();

  relay_pid_regulator_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind),
    .sample_i     (sample),
    .new_action_i (new_action),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .action_o     (action_o),
    .error_o      (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are checked before the input of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) chk.check_result(action_o, error_o);
      if (in_valid && !in_stall_o) chk.take_input(kind, sample, new_action);
      if (cfg_valid && cfg_ready_o) chk.write_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((out_valid_o && !out_stall) || (in_valid && !in_stall_o) ||
                    (cfg_valid && cfg_ready_o)))
      idle_cycles <= idle_cycles + 1;
    else
      idle_cycles <= 0;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [rpr_pkg::CFG_DATA_BITS-1:0] rand_gain();
    logic [rpr_pkg::GAIN_BITS-1:0] g;
    case ($urandom_range(0, 9))
      0:       g = 16'h8000;
      1:       g = 16'h7FFF;
      2:       g = 16'($urandom);
      default: g = 16'($urandom_range(0, 1024) - 512);
    endcase
    return {{16{g[15]}}, g};
  endfunction

  // Receiver: random stalls, stall-free stretches and one long hold on request.
  initial begin
    int n;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  task automatic write_cfg(input rpr_pkg::cfg_idx_e idx,
                           input logic [rpr_pkg::CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_word(input logic k, input logic signed [SAMPLE_W-1:0] s,
                           input logic [rpr_pkg::ACTION_BITS-1:0] a, input int gap);
    in_valid   <= 1'b1;
    kind       <= k;
    sample     <= s;
    new_action <= a;
    do @(posedge clk_i); while (in_stall_o);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The word accepted at the last edge is noted by then, so an empty queue means idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (chk.pending_results.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  initial begin
    int r;
    int span;
    int off;
    logic signed [SAMPLE_W-1:0]        tgt;
    logic [rpr_pkg::GATE_BITS-1:0]     gw;
    logic [rpr_pkg::CFG_DATA_BITS-1:0] lo, hi;
    logic signed [SAMPLE_W-1:0]        smp;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Off mode after reset: nothing moves, but a direct write is still held.
    send_word(1'b0, 16'sh7FFF, 7'd0, 0);
    send_word(1'b1, 16'sh0000, 7'd127, 0);
    drain_results();
    write_cfg(rpr_pkg::CFG_MODE, rpr_pkg::MODE_MANUAL);
    send_word(1'b0, 16'sh8000, 7'd0, 0);
    send_word(1'b1, 16'sh0000, 7'd0, 0);
    send_word(1'b1, 16'sh0000, 7'd100, 0);
    send_word(1'b1, 16'sh0000, 7'd101, 0);
    drain_results();
    write_cfg(rpr_pkg::CFG_MODE, rpr_pkg::MODE_RELAY);
    write_cfg(rpr_pkg::CFG_RELAY_GATE, 32'd100);
    send_word(1'b0, 16'sh7FFF, 7'd0, 0);
    send_word(1'b0, 16'sh8000, 7'd0, 0);
    send_word(1'b0, -16'sd100, 7'd0, 0);
    send_word(1'b0, 16'sd100, 7'd0, 0);
    send_word(1'b0, 16'sd101, 7'd0, 0);
    send_word(1'b0, -16'sd101, 7'd0, 0);
    drain_results();
    // Widest band with the error at both of its extremes.
    write_cfg(rpr_pkg::CFG_RELAY_GATE, 32'h0000_FFFF);
    write_cfg(rpr_pkg::CFG_TARGET, 32'hFFFF_8000);
    send_word(1'b0, 16'sh7FFF, 7'd0, 0);
    drain_results();
    write_cfg(rpr_pkg::CFG_TARGET, 32'h0000_7FFF);
    send_word(1'b0, 16'sh8000, 7'd0, 0);
    send_word(1'b1, 16'sh0000, 7'd37, 0);
    drain_results();
    write_cfg(rpr_pkg::CFG_MODE, rpr_pkg::MODE_PID);
    write_cfg(rpr_pkg::CFG_TARGET, 32'd0);
    write_cfg(rpr_pkg::CFG_RELAY_GATE, 32'd0);
    write_cfg(rpr_pkg::CFG_GAIN_P, 32'd256);
    send_word(1'b0, -16'sd50, 7'd0, 0);
    send_word(1'b0, 16'sh8000, 7'd0, 0);
    send_word(1'b0, 16'sh7FFF, 7'd0, 0);
    drain_results();
    write_cfg(rpr_pkg::CFG_GAIN_P, 32'hFFFF_8000);
    write_cfg(rpr_pkg::CFG_GAIN_I, 32'h0000_7FFF);
    write_cfg(rpr_pkg::CFG_GAIN_D, 32'hFFFF_8000);
    write_cfg(rpr_pkg::CFG_INTEG_MIN, 32'h8000_0000);
    write_cfg(rpr_pkg::CFG_INTEG_MAX, 32'h7FFF_FFFF);
    send_word(1'b0, 16'sh8000, 7'd0, 0);
    send_word(1'b0, 16'sh8000, 7'd0, 0);
    send_word(1'b0, 16'sh7FFF, 7'd0, 0);
    drain_results();
    // Crossed integral bounds: a sum above the maximum settles on it, any other on the minimum.
    write_cfg(rpr_pkg::CFG_GAIN_P, 32'd0);
    write_cfg(rpr_pkg::CFG_GAIN_D, 32'd0);
    write_cfg(rpr_pkg::CFG_GAIN_I, 32'd256);
    write_cfg(rpr_pkg::CFG_INTEG_MIN, 32'd5);
    write_cfg(rpr_pkg::CFG_INTEG_MAX, -32'd5);
    send_word(1'b0, 16'sd0, 7'd0, 0);
    send_word(1'b0, -16'sd1000, 7'd0, 0);
    drain_results();
    write_cfg(rpr_pkg::CFG_MODE, rpr_pkg::MODE_OFF);
    send_word(1'b0, 16'sd5, 7'd0, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      r = $urandom_range(0, 99);
      write_cfg(rpr_pkg::CFG_MODE,
                (r < 40) ? rpr_pkg::MODE_PID : (r < 75) ? rpr_pkg::MODE_RELAY :
                (r < 90) ? rpr_pkg::MODE_MANUAL : rpr_pkg::MODE_OFF);
      case ($urandom_range(0, 4))
        0:       tgt = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        1:       tgt = 16'($urandom);
        default: tgt = 16'($urandom_range(0, 2000) - 1000);
      endcase
      write_cfg(rpr_pkg::CFG_TARGET, {{16{tgt[15]}}, tgt});
      r = $urandom_range(0, 99);
      gw = (r < 10) ? 16'hFFFF : (r < 20) ? 16'h0000 :
           (r < 30) ? 16'($urandom) : 16'($urandom_range(0, 600));
      write_cfg(rpr_pkg::CFG_RELAY_GATE, {16'h0000, gw});
      write_cfg(rpr_pkg::CFG_GAIN_P, rand_gain());
      write_cfg(rpr_pkg::CFG_GAIN_I, rand_gain());
      write_cfg(rpr_pkg::CFG_GAIN_D, rand_gain());
      r = $urandom_range(0, 99);
      if (r < 15) begin
        lo = 32'h8000_0000;
        hi = 32'h7FFF_FFFF;
      end else if (r < 30) begin
        lo = $urandom;
        hi = $urandom;
      end else begin
        lo = -$urandom_range(0, 20000);
        hi = $urandom_range(0, 20000);
      end
      write_cfg(rpr_pkg::CFG_INTEG_MIN, lo);
      write_cfg(rpr_pkg::CFG_INTEG_MAX, hi);

      // The long hold lets the pipeline fill while words keep coming.
      if (ph == 2) hold_req = 1'b1;
      span = ((gw > 2000) ? 2000 : int'(gw)) + 64;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 15) begin
          send_word(1'b1, 16'($urandom), 7'($urandom_range(0, 127)), pick_gap());
        end else if (r < 80) begin
          off = int'($urandom_range(0, 2 * span)) - span;
          smp = 16'(int'(tgt) + off);
          send_word(1'b0, smp, 7'($urandom), (ph == 2) ? 0 : pick_gap());
        end else begin
          send_word(1'b0, 16'($urandom), 7'($urandom), pick_gap());
        end
      end
    end

    drain_results();
    if (chk.mismatches == 0 && chk.pending_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/rpr_pkg.sv
sv/relay_pid_regulator_unit.sv
verif/tb_top.sv
